@@ rtl/core/ctc_pkg.sv @@
package ctc_pkg;

  localparam int unsigned COORD_BITS_DEF = 12;
  localparam int unsigned COUNT_BITS_DEF = 16;

  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned MIN_HITS_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CH0_LOW  = 3'd0,
    REG_CH0_HIGH = 3'd1,
    REG_CH1_LOW  = 3'd2,
    REG_CH1_HIGH = 3'd3,
    REG_CH2_LOW  = 3'd4,
    REG_CH2_HIGH = 3'd5,
    REG_MIN_HITS = 3'd6
  } cfg_reg_t;

  localparam logic [CHAN_W-1:0]     CH0_LOW_RST  = 8'd20;
  localparam logic [CHAN_W-1:0]     CH0_HIGH_RST = 8'd38;
  localparam logic [CHAN_W-1:0]     CH1_LOW_RST  = 8'd170;
  localparam logic [CHAN_W-1:0]     CH1_HIGH_RST = 8'd210;
  localparam logic [CHAN_W-1:0]     CH2_LOW_RST  = 8'd90;
  localparam logic [CHAN_W-1:0]     CH2_HIGH_RST = 8'd200;
  localparam logic [MIN_HITS_W-1:0] MIN_HITS_RST = 16'd20;

  // one-hot controller states
  typedef enum logic [2:0] {
    ST_ACC  = 3'b001,
    ST_DIV  = 3'b010,
    ST_DONE = 3'b100
  } ctc_state_t;

  typedef struct packed {
    logic pix_take;  // pixel beat accepted this cycle
    logic div_load;  // end of frame: seed divider, clear sums
    logic div_step;  // one quotient bit of both divisions
    logic out_load;  // capture result into output register
  } ctc_cmd_t;

endpackage

@@ rtl/core/ctc_ctrl.sv @@
module ctc_ctrl
  import ctc_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_end_of_frame,
  output logic     in_ready,
  input  logic     out_ready,
  output logic     out_valid,
  output ctc_cmd_t cmd
);

  localparam int unsigned STEP_W = $clog2(COORD_BITS);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(COORD_BITS - 1);

  ctc_state_t        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_ACC: begin
        in_ready     = 1'b1;
        cmd.pix_take = in_valid;
        if (in_valid && in_end_of_frame) begin
          cmd.div_load = 1'b1;
          step_nxt     = '0;
          state_nxt    = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + 1'b1;
        if (step_r == STEP_LAST) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // hold until the output register is free or being drained
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_ACC;
        end
      end
      default: begin
        state_nxt = ST_ACC;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_ACC;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

@@ rtl/core/ctc_dpath.sv @@
module ctc_dpath
  import ctc_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ctc_cmd_t              cmd,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [CHAN_W-1:0]     in_chan_hue,
  input  logic [CHAN_W-1:0]     in_chan_sat,
  input  logic [CHAN_W-1:0]     in_chan_val,
  input  logic [COORD_BITS-1:0] in_x_pos,
  input  logic [COORD_BITS-1:0] in_y_pos,
  output logic [COORD_BITS-1:0] out_centroid_x,
  output logic [COORD_BITS-1:0] out_centroid_y,
  output logic                  out_target_found,
  output logic [COUNT_BITS-1:0] out_hits_in_frame
);

  localparam int unsigned ACC_W = COORD_BITS + COUNT_BITS;
  localparam int unsigned CMP_W = (COUNT_BITS > MIN_HITS_W) ? COUNT_BITS : MIN_HITS_W;

  logic [CHAN_W-1:0]     ch0_low_r, ch0_high_r, ch1_low_r, ch1_high_r, ch2_low_r, ch2_high_r;
  logic [MIN_HITS_W-1:0] min_hits_r;

  logic [ACC_W-1:0]      x_acc_r, y_acc_r, x_acc_nxt, y_acc_nxt, x_sum, y_sum;
  logic [COUNT_BITS-1:0] tally_r, tally_nxt, tally_sum;
  logic                  hit, can_add;

  logic [COUNT_BITS-1:0] rem_x_r, rem_y_r, div_r;
  logic [COORD_BITS-1:0] quo_x_r, quo_y_r;
  logic [COUNT_BITS:0]   sh_x, sh_y;
  logic [COUNT_BITS+1:0] diff_x, diff_y;
  logic                  ge_x, ge_y, found;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch0_low_r  <= CH0_LOW_RST;
      ch0_high_r <= CH0_HIGH_RST;
      ch1_low_r  <= CH1_LOW_RST;
      ch1_high_r <= CH1_HIGH_RST;
      ch2_low_r  <= CH2_LOW_RST;
      ch2_high_r <= CH2_HIGH_RST;
      min_hits_r <= MIN_HITS_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CH0_LOW:  ch0_low_r  <= cfg_data[CHAN_W-1:0];
        REG_CH0_HIGH: ch0_high_r <= cfg_data[CHAN_W-1:0];
        REG_CH1_LOW:  ch1_low_r  <= cfg_data[CHAN_W-1:0];
        REG_CH1_HIGH: ch1_high_r <= cfg_data[CHAN_W-1:0];
        REG_CH2_LOW:  ch2_low_r  <= cfg_data[CHAN_W-1:0];
        REG_CH2_HIGH: ch2_high_r <= cfg_data[CHAN_W-1:0];
        REG_MIN_HITS: min_hits_r <= cfg_data[MIN_HITS_W-1:0];
        default: ;
      endcase
    end
  end

  // pixel classification and accumulation
  assign hit = (in_chan_hue > ch0_low_r) && (in_chan_hue < ch0_high_r) &&
               (in_chan_sat > ch1_low_r) && (in_chan_sat < ch1_high_r) &&
               (in_chan_val > ch2_low_r) && (in_chan_val < ch2_high_r);

  // drop hits once the count is saturated
  assign can_add   = hit && (tally_r != {COUNT_BITS{1'b1}});
  assign x_sum     = can_add ? x_acc_r + ACC_W'(in_x_pos) : x_acc_r;
  assign y_sum     = can_add ? y_acc_r + ACC_W'(in_y_pos) : y_acc_r;
  assign tally_sum = can_add ? tally_r + 1'b1 : tally_r;

  always_comb begin
    x_acc_nxt = x_acc_r;
    y_acc_nxt = y_acc_r;
    tally_nxt = tally_r;
    if (cmd.div_load) begin
      x_acc_nxt = '0;
      y_acc_nxt = '0;
      tally_nxt = '0;
    end else if (cmd.pix_take) begin
      x_acc_nxt = x_sum;
      y_acc_nxt = y_sum;
      tally_nxt = tally_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_acc_r <= '0;
      y_acc_r <= '0;
      tally_r <= '0;
    end else begin
      x_acc_r <= x_acc_nxt;
      y_acc_r <= y_acc_nxt;
      tally_r <= tally_nxt;
    end
  end

  // restoring divider, both axes share the divisor; the mean fits in
  // COORD_BITS, so the upper sum bits seed the remainder directly
  assign sh_x   = {rem_x_r, quo_x_r[COORD_BITS-1]};
  assign sh_y   = {rem_y_r, quo_y_r[COORD_BITS-1]};
  assign diff_x = {1'b0, sh_x} - {2'b00, div_r};
  assign diff_y = {1'b0, sh_y} - {2'b00, div_r};
  assign ge_x   = !diff_x[COUNT_BITS+1];
  assign ge_y   = !diff_y[COUNT_BITS+1];

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      rem_x_r <= x_sum[ACC_W-1:COORD_BITS];
      quo_x_r <= x_sum[COORD_BITS-1:0];
      rem_y_r <= y_sum[ACC_W-1:COORD_BITS];
      quo_y_r <= y_sum[COORD_BITS-1:0];
      div_r   <= tally_sum;
    end else if (cmd.div_step) begin
      rem_x_r <= ge_x ? diff_x[COUNT_BITS-1:0] : sh_x[COUNT_BITS-1:0];
      rem_y_r <= ge_y ? diff_y[COUNT_BITS-1:0] : sh_y[COUNT_BITS-1:0];
      quo_x_r <= {quo_x_r[COORD_BITS-2:0], ge_x};
      quo_y_r <= {quo_y_r[COORD_BITS-2:0], ge_y};
    end
  end

  // result register
  assign found = CMP_W'(div_r) > CMP_W'(min_hits_r);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_centroid_x    <= found ? quo_x_r : '0;
      out_centroid_y    <= found ? quo_y_r : '0;
      out_target_found  <= found;
      out_hits_in_frame <= div_r;
    end
  end

endmodule

@@ rtl/core/color_threshold_centroid.sv @@
// Color threshold centroid.
// Input channel (in_valid/in_ready): one sampled pixel per beat, three channel
// bytes, column, row and an end-of-frame mark. Pixels inside all three open
// bounds are hits; their coordinates are summed and counted per frame.
// Output channel (out_valid/out_ready): one beat per frame, produced by the
// pixel carrying end_of_frame: mean column and row (0 when not found), the
// found flag (count above min_hits) and the saturating hit count.
// Config channel (cfg_valid/cfg_ready): always ready, index selects the bound
// or min_hits register; unknown indexes are ignored. Write only when idle.
// Throughput: one pixel per cycle inside a frame. After the end-of-frame beat
// the input stalls while a shared restoring divider produces one quotient bit
// per cycle for both axes; the block then loads the result into the output
// register, which raises out_valid.
// If the previous result has not been taken, the block holds in its final
// step until the output register frees, then resumes taking pixels.
// Reset: bounds and min_hits return to their defaults, sums and count clear,
// no result pending.
module color_threshold_centroid
  import ctc_pkg::*;
#(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF,
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [CHAN_W-1:0]     in_chan_hue,
  input  logic [CHAN_W-1:0]     in_chan_sat,
  input  logic [CHAN_W-1:0]     in_chan_val,
  input  logic [COORD_BITS-1:0] in_x_pos,
  input  logic [COORD_BITS-1:0] in_y_pos,
  input  logic                  in_end_of_frame,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [COORD_BITS-1:0] out_centroid_x,
  output logic [COORD_BITS-1:0] out_centroid_y,
  output logic                  out_target_found,
  output logic [COUNT_BITS-1:0] out_hits_in_frame,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  ctc_cmd_t cmd;

  assign cfg_ready = 1'b1;

  ctc_ctrl #(
    .COORD_BITS (COORD_BITS)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_end_of_frame (in_end_of_frame),
    .in_ready        (in_ready),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .cmd             (cmd)
  );

  ctc_dpath #(
    .COORD_BITS (COORD_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .cfg_we            (cfg_valid),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_chan_hue       (in_chan_hue),
    .in_chan_sat       (in_chan_sat),
    .in_chan_val       (in_chan_val),
    .in_x_pos          (in_x_pos),
    .in_y_pos          (in_y_pos),
    .out_centroid_x    (out_centroid_x),
    .out_centroid_y    (out_centroid_y),
    .out_target_found  (out_target_found),
    .out_hits_in_frame (out_hits_in_frame)
  );

endmodule
